>>> hw/rtl/pid_pkg.sv
// pid_pkg: widths, register indexes and controller/datapath command types
// for the pid controller with anti-windup.
// No dependencies; imported by every module of the block.
package pid_pkg;

  // field and intermediate widths
  localparam int ERR_W      = 16;   // saturated error, previous error
  localparam int DERR_W     = 17;   // error change
  localparam int GAIN_W     = 16;   // proportional and derivative gains
  localparam int MUL_W      = 17;   // multiplier operand width
  localparam int PROD_W     = 33;   // 16 x 17 signed product
  localparam int PD_W       = 34;   // proportional plus derivative term
  localparam int INT_W      = 32;   // stored integral
  localparam int ISUM_W     = 34;   // integral plus increment before clamp
  localparam int TOT_W      = 36;   // full sum of all three terms
  localparam int KDIV_W     = 15;   // integral divisor register
  localparam int DRV_W      = 16;   // drive output and drive limits

  // integral divider: 16-bit magnitude dividend, divisor register width,
  // two quotient bits per cycle
  localparam int DVD_W      = 16;
  localparam int DVS_W      = KDIV_W;
  localparam int DIV_RADIX  = 2;
  localparam int DIV_STEPS  = DVD_W / DIV_RADIX;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int OUT_SCALE_DEF = 128;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INT_DIVISOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDUP_BAND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INT_UPPER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LOWER   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRV_UPPER   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DRV_LOWER   = 3'd7;

  // input mode codes
  localparam logic MODE_STEP  = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic take_err;    // latch saturated error of the accepted beat
    logic clr_int;     // clear the stored integral
    logic pmul;        // proportional product, error change, start integral divide
    logic dmul;        // derivative product
    logic pd_sum;      // add proportional and derivative terms
    logic int_upd;     // accumulate and clamp the integral
    logic tot_sum;     // add integral to the term sum
    logic out_clamp;   // clamp the sum, latch its sign and magnitude
    logic out_scale;   // scale the magnitude by the reciprocal of the output scale
    logic out_load;    // load the scaled result into the output register
  } pid_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
  } pid_sts_t;

endpackage

>>> hw/rtl/pid_div.sv
// pid_div: sequential unsigned divider, two quotient bits per cycle,
// truncating. Used for the integral step.
// Depends on pid_pkg.
module pid_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pid_pkg::DVD_W-1:0]  dividend,
  input  logic [pid_pkg::DVS_W-1:0]  divisor,
  output logic [pid_pkg::DVD_W-1:0]  quotient,
  output logic                       done
);
  import pid_pkg::*;

  logic [DVD_W-1:0]     dvd_r, dvd_nxt;   // dividend bits out, quotient bits in
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  // restoring steps for one cycle
  always_comb begin
    logic [DVS_W:0]   shl;
    logic [DVS_W-1:0] rem;
    logic [DVD_W-1:0] dvd;
    rem = rem_r;
    dvd = dvd_r;
    for (int i = 0; i < DIV_RADIX; i++) begin
      shl = {rem, dvd[DVD_W-1]};
      dvd = {dvd[DVD_W-2:0], 1'b0};
      if (shl >= {1'b0, dvs_r}) begin
        rem    = DVS_W'(shl - {1'b0, dvs_r});
        dvd[0] = 1'b1;
      end else begin
        rem = shl[DVS_W-1:0];
      end
    end
    rem_nxt = rem;
    dvd_nxt = dvd;
  end

  // step counter and completion flag
  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = dvd_r;
  assign done     = done_r;

endmodule

>>> hw/rtl/pid_dp.sv
// pid_dp: pid datapath with configuration registers, integral and previous
// error state, shared multiplier, integral divider and output register.
// Depends on pid_pkg and pid_div.
module pid_dp #(
  parameter int OUT_SCALE = pid_pkg::OUT_SCALE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [pid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pid_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic signed [15:0]              in_target,
  input  logic signed [15:0]              in_measured,
  input  pid_pkg::pid_cmd_t               cmd,
  output pid_pkg::pid_sts_t               sts,
  output logic signed [15:0]              out_drive
);
  import pid_pkg::*;

  // output scaling by reciprocal multiply, exact for magnitudes below 2**DVD_W
  localparam int     SCL_SH    = DVD_W + $clog2(OUT_SCALE);
  localparam int     SCL_M_W   = DVD_W + 1;
  localparam longint SCL_RECIP = ((longint'(1) << SCL_SH) + longint'(OUT_SCALE) - 1)
                                 / longint'(OUT_SCALE);
  localparam logic [SCL_M_W-1:0] SCL_M = SCL_M_W'(SCL_RECIP);

  // configuration registers
  logic signed [GAIN_W-1:0] kp_r, kd_r;
  logic [KDIV_W-1:0]        kdiv_r;
  logic [15:0]              band_r;
  logic signed [INT_W-1:0]  iup_r, ilo_r;
  logic signed [DRV_W-1:0]  dup_r, dlo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= '0;
      kdiv_r <= KDIV_W'(1);
      kd_r   <= '0;
      band_r <= 16'h8000;
      iup_r  <= INT_W'(32767);
      ilo_r  <= -INT_W'(32768);
      dup_r  <= 16'sh7FFF;
      dlo_r  <= 16'sh8000;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PROP_GAIN:   kp_r   <= cfg_wdata[GAIN_W-1:0];
        REG_INT_DIVISOR: kdiv_r <= cfg_wdata[KDIV_W-1:0];
        REG_DERIV_GAIN:  kd_r   <= cfg_wdata[GAIN_W-1:0];
        REG_WINDUP_BAND: band_r <= cfg_wdata[15:0];
        REG_INT_UPPER:   iup_r  <= cfg_wdata[INT_W-1:0];
        REG_INT_LOWER:   ilo_r  <= cfg_wdata[INT_W-1:0];
        REG_DRV_UPPER:   dup_r  <= cfg_wdata[DRV_W-1:0];
        REG_DRV_LOWER:   dlo_r  <= cfg_wdata[DRV_W-1:0];
        default: ;
      endcase
    end
  end

  // working registers
  logic signed [ERR_W-1:0]  err_r, prev_r;
  logic signed [DERR_W-1:0] derr_r;
  logic signed [PROD_W-1:0] prod_r, pterm_r;
  logic signed [PD_W-1:0]   pd_r;
  logic signed [INT_W-1:0]  integ_r, integ_nxt;
  logic signed [TOT_W-1:0]  tot_r;
  logic                     neg_r;
  logic [DVD_W-1:0]         cl_abs_r, scl_r;
  logic signed [DRV_W-1:0]  drive_r;

  // saturated error of the incoming beat
  logic signed [ERR_W:0]   diff;
  logic signed [ERR_W-1:0] err_sat;
  always_comb begin
    diff = {in_target[15], in_target} - {in_measured[15], in_measured};
    if (diff[ERR_W] != diff[ERR_W-1]) begin
      err_sat = diff[ERR_W] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      err_sat = diff[ERR_W-1:0];
    end
  end

  // error magnitude and windup gate
  logic [ERR_W:0] mag;
  logic           win;
  assign mag = err_r[ERR_W-1] ? (ERR_W+1)'(-{err_r[ERR_W-1], err_r})
                              : {1'b0, err_r};
  assign win = mag < {1'b0, band_r};

  // shared multiplier
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_full;
  assign mul_a    = cmd.dmul ? {kd_r[GAIN_W-1], kd_r} : {kp_r[GAIN_W-1], kp_r};
  assign mul_b    = cmd.dmul ? derr_r : {err_r[ERR_W-1], err_r};
  assign mul_full = mul_a * mul_b;

  // integral divider, a zero divisor acts as one
  logic             div_start;
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;

  assign div_start = cmd.pmul;
  assign div_dvd   = mag[DVD_W-1:0];
  assign div_dvs   = (kdiv_r == '0) ? DVS_W'(1) : kdiv_r;

  pid_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .done     (div_done)
  );

  assign sts.div_done = div_done;

  // integral accumulate and clamp, upper limit tested first
  always_comb begin
    logic signed [ISUM_W-1:0] inc, isum;
    inc = '0;
    if (win) begin
      inc = err_r[ERR_W-1] ? -ISUM_W'(div_q) : ISUM_W'(div_q);
    end
    isum = {{(ISUM_W-INT_W){integ_r[INT_W-1]}}, integ_r} + inc;
    if (isum > $signed({{(ISUM_W-INT_W){iup_r[INT_W-1]}}, iup_r})) begin
      integ_nxt = iup_r;
    end else if (isum < $signed({{(ISUM_W-INT_W){ilo_r[INT_W-1]}}, ilo_r})) begin
      integ_nxt = ilo_r;
    end else begin
      integ_nxt = isum[INT_W-1:0];
    end
  end

  // drive clamp of the full sum and its magnitude
  logic signed [DRV_W-1:0] cl;
  logic [DVD_W-1:0]        cl_abs;
  always_comb begin
    if (tot_r > $signed({{(TOT_W-DRV_W){dup_r[DRV_W-1]}}, dup_r})) begin
      cl = dup_r;
    end else if (tot_r < $signed({{(TOT_W-DRV_W){dlo_r[DRV_W-1]}}, dlo_r})) begin
      cl = dlo_r;
    end else begin
      cl = tot_r[DRV_W-1:0];
    end
    cl_abs = cl[DRV_W-1] ? DVD_W'(-{cl[DRV_W-1], cl}) : cl;
  end

  // scaled magnitude, truncating
  logic [DVD_W+SCL_M_W-1:0] scl_prod;
  logic [DVD_W-1:0]         scl_q;
  assign scl_prod = cl_abs_r * SCL_M;
  assign scl_q    = DVD_W'(scl_prod >> SCL_SH);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      prev_r  <= '0;
    end else begin
      if (cmd.clr_int) begin
        integ_r <= '0;
      end else if (cmd.int_upd) begin
        integ_r <= integ_nxt;
      end
      if (cmd.pmul) begin
        prev_r <= err_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_err) begin
      err_r <= err_sat;
    end
    if (cmd.pmul) begin
      prod_r <= mul_full[PROD_W-1:0];
      derr_r <= {err_r[ERR_W-1], err_r} - {prev_r[ERR_W-1], prev_r};
    end
    if (cmd.dmul) begin
      pterm_r <= prod_r;
      prod_r  <= mul_full[PROD_W-1:0];
    end
    if (cmd.pd_sum) begin
      pd_r <= {pterm_r[PROD_W-1], pterm_r} + {prod_r[PROD_W-1], prod_r};
    end
    if (cmd.tot_sum) begin
      tot_r <= {{(TOT_W-PD_W){pd_r[PD_W-1]}}, pd_r}
             + {{(TOT_W-INT_W){integ_r[INT_W-1]}}, integ_r};
    end
    if (cmd.out_clamp) begin
      neg_r    <= cl[DRV_W-1];
      cl_abs_r <= cl_abs;
    end
    if (cmd.out_scale) begin
      scl_r <= scl_q;
    end
    if (cmd.out_load) begin
      drive_r <= neg_r ? DRV_W'(-scl_r) : scl_r;
    end
  end

  assign out_drive = drive_r;

endmodule

>>> hw/rtl/pid_ctrl.sv
// pid_ctrl: sequencing state machine of the pid controller; drives the
// datapath commands and both handshakes.
// Depends on pid_pkg.
module pid_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_mode,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output pid_pkg::pid_cmd_t  cmd,
  input  pid_pkg::pid_sts_t  sts
);
  import pid_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PMUL  = 9'b000000010,
    S_DMUL  = 9'b000000100,
    S_PDSUM = 9'b000001000,
    S_IWAIT = 9'b000010000,
    S_TSUM  = 9'b000100000,
    S_CLAMP = 9'b001000000,
    S_SCALE = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid & in_ready;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r & ~out_ready;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_CLEAR) begin
            cmd.clr_int = 1'b1;
          end else begin
            cmd.take_err = 1'b1;
            state_nxt    = S_PMUL;
          end
        end
      end
      S_PMUL: begin
        cmd.pmul  = 1'b1;
        state_nxt = S_DMUL;
      end
      S_DMUL: begin
        cmd.dmul  = 1'b1;
        state_nxt = S_PDSUM;
      end
      S_PDSUM: begin
        cmd.pd_sum = 1'b1;
        state_nxt  = S_IWAIT;
      end
      S_IWAIT: begin
        if (sts.div_done) begin
          cmd.int_upd = 1'b1;
          state_nxt   = S_TSUM;
        end
      end
      S_TSUM: begin
        cmd.tot_sum = 1'b1;
        state_nxt   = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.out_clamp = 1'b1;
        state_nxt     = S_SCALE;
      end
      S_SCALE: begin
        cmd.out_scale = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/pid_controller_antiwindup_top.sv
// pid_controller_antiwindup_top: top level of the pid controller with
// anti-windup; joins the controller state machine and the datapath.
// Depends on pid_pkg, pid_ctrl, pid_dp (and pid_div below it).
//
// Usage:
//   Input beats (in_valid/in_ready) carry in_mode, in_target, in_measured.
//   A mode-0 beat runs one control step and yields one out_drive beat
//   (out_valid/out_ready). A mode-1 beat clears the integral in its accept
//   cycle and yields nothing; the next beat can follow at once.
//   Registers are written through cfg_wr_en/cfg_index/cfg_wdata with no wait;
//   the user must write only while the block is idle, which is not enforced.
// Sequencing:
//   A control step runs from accept through S_PMUL, S_DMUL, S_PDSUM, S_IWAIT,
//   S_TSUM, S_CLAMP, S_SCALE and S_OUT to out_valid; in_ready comes back in
//   that same cycle, and no new sample is taken while a step runs. Most of it
//   is the integral divide; output scaling is a single reciprocal multiply.
// Reset (rst_n low, synchronous) clears integral and previous error, loads
//   the register reset values and empties the output register.
// Stall: a finished result waits in the output register; the block still
//   accepts and works on the next beat and holds only if that one is done
//   before the earlier result is taken.
module pid_controller_antiwindup_top #(
  parameter int OUT_SCALE = pid_pkg::OUT_SCALE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode,
  input  logic signed [15:0]              in_target,
  input  logic signed [15:0]              in_measured,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [15:0]              out_drive,
  input  logic                            cfg_wr_en,
  input  logic [pid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pid_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import pid_pkg::*;

  pid_cmd_t cmd;
  pid_sts_t sts;

  // sequencing
  pid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // arithmetic and state
  pid_dp #(
    .OUT_SCALE (OUT_SCALE)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_target   (in_target),
    .in_measured (in_measured),
    .cmd         (cmd),
    .sts         (sts),
    .out_drive   (out_drive)
  );

endmodule
